// ===== hdl/jsfx_pkg.sv =====
// Shared types, sizes and character codes for the JSON string field extractor.
// Used by the interfaces, the parser, the result drain and the top level.
`default_nettype none

package jsfx_pkg;

  // Sizes
  localparam int KEY_MAX_BYTES   = 8;
  localparam int VALUE_MAX_BYTES = 64;

  localparam int WIN_DEPTH  = KEY_MAX_BYTES + 2;
  localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
  localparam int CNT_W      = $clog2(VALUE_MAX_BYTES + 1);
  localparam int PTR_W      = $clog2(VALUE_MAX_BYTES);
  localparam int RAM_DEPTH  = 2 * VALUE_MAX_BYTES;
  localparam int RAM_AW     = PTR_W + 1;
  localparam int CMP_W      = ((CNT_W > 7) ? CNT_W : 7) + 1;

  // Field widths
  localparam int KEY_CHARS_W   = 64;
  localparam int KEY_LENGTH_W  = 4;
  localparam int VALUE_LIMIT_W = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  // Character codes
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_CHARS   = 2'd0,
    CFG_KEY_LENGTH  = 2'd1,
    CFG_VALUE_LIMIT = 2'd2
  } cfg_index_t;

  // Parse phases
  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_COLON,
    PH_OPENQ,
    PH_VALUE,
    PH_ESCAPE,
    PH_DONE,
    PH_FAIL
  } parse_phase_t;

  // Configuration as seen by the parser
  typedef struct packed {
    logic [KEY_CHARS_W-1:0]   key_chars;
    logic [KEY_LENGTH_W-1:0]  key_length;
    logic [VALUE_LIMIT_W-1:0] value_limit;
  } cfg_t;

  // Finished payload handed from parser to drain
  typedef struct packed {
    logic             valid;
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             found;
  } job_t;

  // Value store write port
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jsfx_if.sv =====
// Valid/ready channel interfaces: text input, result output, register write.
// Depends on jsfx_pkg for field widths.
`default_nettype none

interface jsfx_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsfx_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       found;
  logic       last_of_run;
  modport source (output valid, output value_byte, output found, output last_of_run,
                  input ready);
  modport sink   (input valid, input value_byte, input found, input last_of_run,
                  output ready);
endinterface

interface jsfx_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [jsfx_pkg::CFG_IDX_W-1:0] index;
  logic [jsfx_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/jsfx_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package use.
`default_nettype none

module jsfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/jsfx_parser.sv =====
// Byte parser: key window, parse phase, value count and value store writes.
// Depends on jsfx_pkg and jsfx_text_if; hands finished payloads to the drain.
`default_nettype none

module jsfx_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  jsfx_text_if.sink          text,
  input  wire jsfx_pkg::cfg_t cfg,
  input  wire logic          hold,
  output jsfx_pkg::job_t     job,
  output jsfx_pkg::ram_wr_t  wr
);

  logic [7:0]                  window [jsfx_pkg::WIN_DEPTH];
  logic [7:0]                  w_new  [jsfx_pkg::WIN_DEPTH];
  jsfx_pkg::parse_phase_t      phase, phase_next;
  logic [jsfx_pkg::CNT_W-1:0]  count, count_next;
  logic                        text_ended;
  logic                        wr_bank;

  logic                            fire, take, keep, match, room;
  logic [7:0]                      b;
  logic [jsfx_pkg::KEY_LENGTH_W-1:0] kl;
  logic [jsfx_pkg::CMP_W-1:0]      lim;

  assign text.ready = !hold;
  assign fire = text.valid && !hold;
  assign b    = text.text_byte;
  assign take = fire && !text_ended && (b != jsfx_pkg::CH_NUL);

  // Saturate key length and value limit
  assign kl = (cfg.key_length > jsfx_pkg::KEY_LENGTH_W'(jsfx_pkg::KEY_MAX_BYTES)) ?
              jsfx_pkg::KEY_LENGTH_W'(jsfx_pkg::KEY_MAX_BYTES) : cfg.key_length;
  assign lim = (jsfx_pkg::CMP_W'(cfg.value_limit) > jsfx_pkg::CMP_W'(jsfx_pkg::VALUE_MAX_BYTES))
             ? jsfx_pkg::CMP_W'(jsfx_pkg::VALUE_MAX_BYTES)
             : jsfx_pkg::CMP_W'(cfg.value_limit);
  assign room = (jsfx_pkg::CMP_W'(count) + jsfx_pkg::CMP_W'(1)) < lim;

  // Shifted window with the new byte at the front
  always_comb begin
    w_new[0] = b;
    for (int i = 1; i < jsfx_pkg::WIN_DEPTH; i++) begin
      w_new[i] = window[i-1];
    end
  end

  // Compare quote, key and quote, newest byte last
  always_comb begin
    match = (w_new[0] == jsfx_pkg::CH_QUOTE) &&
            (w_new[jsfx_pkg::WIN_IDX_W'(kl) + jsfx_pkg::WIN_IDX_W'(1)] == jsfx_pkg::CH_QUOTE);
    for (int i = 0; i < jsfx_pkg::KEY_MAX_BYTES; i++) begin
      if ((jsfx_pkg::KEY_LENGTH_W'(i) < kl) &&
          (w_new[jsfx_pkg::WIN_IDX_W'(kl) - jsfx_pkg::WIN_IDX_W'(i)] !=
           cfg.key_chars[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      case (phase)
        jsfx_pkg::PH_SEARCH: begin
          if (match) phase_next = jsfx_pkg::PH_COLON;
        end
        jsfx_pkg::PH_COLON: begin
          if (!jsfx_pkg::is_space(b)) begin
            phase_next = (b == jsfx_pkg::CH_COLON) ? jsfx_pkg::PH_OPENQ : jsfx_pkg::PH_FAIL;
          end
        end
        jsfx_pkg::PH_OPENQ: begin
          if (!jsfx_pkg::is_space(b)) begin
            phase_next = (b == jsfx_pkg::CH_QUOTE) ? jsfx_pkg::PH_VALUE : jsfx_pkg::PH_FAIL;
          end
        end
        jsfx_pkg::PH_VALUE: begin
          if (b == jsfx_pkg::CH_QUOTE) begin
            phase_next = jsfx_pkg::PH_DONE;
          end else if (b == jsfx_pkg::CH_BACKSLASH) begin
            phase_next = jsfx_pkg::PH_ESCAPE;
          end
        end
        jsfx_pkg::PH_ESCAPE: phase_next = jsfx_pkg::PH_VALUE;
        default:             phase_next = phase;
      endcase
    end
  end

  // Phase outputs: keep a value byte while there is room
  always_comb begin
    keep = 1'b0;
    case (phase)
      jsfx_pkg::PH_VALUE:  keep = take && (b != jsfx_pkg::CH_QUOTE) && room;
      jsfx_pkg::PH_ESCAPE: keep = take && room;
      default:             keep = 1'b0;
    endcase
  end

  assign count_next = count + jsfx_pkg::CNT_W'(keep);

  assign wr.we   = keep;
  assign wr.addr = {wr_bank, count[jsfx_pkg::PTR_W-1:0]};
  assign wr.data = b;

  // Hand over the payload on its final beat
  assign job.valid = fire && text.end_of_text;
  assign job.bank  = wr_bank;
  assign job.count = count_next;
  assign job.found = (phase_next == jsfx_pkg::PH_DONE) && (count_next != '0);

  // Parse state; clear it after each payload and flip the store bank
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= jsfx_pkg::PH_SEARCH;
      count      <= '0;
      text_ended <= 1'b0;
      wr_bank    <= 1'b0;
      for (int i = 0; i < jsfx_pkg::WIN_DEPTH; i++) window[i] <= '0;
    end else if (fire && text.end_of_text) begin
      phase      <= jsfx_pkg::PH_SEARCH;
      count      <= '0;
      text_ended <= 1'b0;
      wr_bank    <= !wr_bank;
      for (int i = 0; i < jsfx_pkg::WIN_DEPTH; i++) window[i] <= '0;
    end else if (fire) begin
      phase <= phase_next;
      count <= count_next;
      if (!text_ended && (b == jsfx_pkg::CH_NUL)) text_ended <= 1'b1;
      if (take && (phase == jsfx_pkg::PH_SEARCH)) begin
        for (int i = 0; i < jsfx_pkg::WIN_DEPTH; i++) window[i] <= w_new[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/jsfx_drain.sv =====
// Result drain: holds one running and one queued payload, reads the value
// store and feeds a two-beat output queue. Depends on jsfx_pkg, jsfx_result_if.
`default_nettype none

module jsfx_drain (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire jsfx_pkg::job_t               job,
  output logic                              hold,
  output logic [jsfx_pkg::RAM_AW-1:0]       raddr,
  input  wire logic [7:0]                   rdata,
  jsfx_result_if.source                     result
);

  // Running and queued payloads
  logic                        active, pending;
  logic                        cur_bank, cur_found, pend_bank, pend_found;
  logic [jsfx_pkg::CNT_W-1:0]  cur_count, pend_count;
  logic [jsfx_pkg::PTR_W-1:0]  rd_ptr;

  // Read return stage
  logic ret_valid, ret_found, ret_last;

  // Output queue
  logic [7:0] q_byte  [2];
  logic       q_found [2];
  logic       q_last  [2];
  logic       q_wr, q_rd;
  logic [1:0] occ;

  logic issue, issue_last, drain_done, pop;

  assign pop   = (occ != 2'd0) && result.ready;
  assign issue = active &&
                 ((3'(occ) + 3'(ret_valid)) <= (3'd1 + 3'(pop)));
  assign issue_last = !cur_found ||
                      ((jsfx_pkg::CNT_W'(rd_ptr) + jsfx_pkg::CNT_W'(1)) == cur_count);
  assign drain_done = issue && issue_last;
  assign raddr = {cur_bank, rd_ptr};

  // A queued payload blocks the parser: its next bank is still being read
  assign hold = pending;

  assign result.valid       = (occ != 2'd0);
  assign result.value_byte  = q_byte[q_rd];
  assign result.found       = q_found[q_rd];
  assign result.last_of_run = q_last[q_rd];

  // Payload bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (job.valid && (!active || drain_done)) begin
        active <= 1'b1;
      end else if (drain_done && pending) begin
        pending <= 1'b0;
      end else if (drain_done) begin
        active <= 1'b0;
      end
      if (job.valid && active && !drain_done) begin
        pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.valid && (!active || drain_done)) begin
      cur_bank  <= job.bank;
      cur_count <= job.count;
      cur_found <= job.found;
      rd_ptr    <= '0;
    end else if (drain_done && pending) begin
      cur_bank  <= pend_bank;
      cur_count <= pend_count;
      cur_found <= pend_found;
      rd_ptr    <= '0;
    end else if (issue) begin
      rd_ptr <= rd_ptr + jsfx_pkg::PTR_W'(1);
    end
    if (job.valid && active && !drain_done) begin
      pend_bank  <= job.bank;
      pend_count <= job.count;
      pend_found <= job.found;
    end
  end

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      ret_valid <= 1'b0;
    end else begin
      ret_valid <= issue;
    end
    ret_found <= cur_found;
    ret_last  <= issue_last;
  end

  // Push returned beats, pop on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr <= 1'b0;
      q_rd <= 1'b0;
      occ  <= 2'd0;
    end else begin
      if (ret_valid) q_wr <= !q_wr;
      if (pop)       q_rd <= !q_rd;
      occ <= occ + 2'(ret_valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ret_valid) begin
      q_byte[q_wr]  <= ret_found ? rdata : 8'h00;
      q_found[q_wr] <= ret_found;
      q_last[q_wr]  <= ret_last;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst) occ <= 2'd2)
    else $error("output queue overflow");

  a_return_room: assert property (@(posedge clk) disable iff (rst)
    ret_valid |-> ((occ != 2'd2) || pop))
    else $error("read returned into a full queue");

  a_pending_active: assert property (@(posedge clk) disable iff (rst)
    pending |-> active)
    else $error("queued payload without a running one");

  a_no_third_job: assert property (@(posedge clk) disable iff (rst)
    job.valid |-> !pending)
    else $error("payload finished while another was queued");

  a_bank_apart: assert property (@(posedge clk) disable iff (rst)
    (pending && active) |-> (pend_bank != cur_bank))
    else $error("running and queued payloads share a bank");

endmodule

`default_nettype wire

// ===== hdl/json_string_field_extractor_core.sv =====
// JSON string field extractor: text bytes in, extracted value bytes out.
// Instantiates jsfx_parser, jsfx_drain and jsfx_ram; uses jsfx_pkg, jsfx_if.
//
// It takes one text byte per cycle on the text channel unless held. Parsing
// state (key window, phase, count) updates in the cycle a beat is accepted, and
// kept value bytes go to a value store RAM split into two banks, so one payload
// is parsed while the result run of the previous one is read out. A result run
// leaves at one beat per cycle while result ready is high, through a two-entry
// output queue fed by the RAM's single read port, one read per beat. The final
// byte of a payload is taken even while an earlier run is still draining; the
// following payload then waits (text ready low) until that earlier run has
// issued its last read, since both banks are in use. There is no clearing pass
// after reset: only entries written in the current payload are output.
// Registers are written through the cfg channel, which is always ready.
`default_nettype none

module json_string_field_extractor_core (
  input  wire logic     clk,
  input  wire logic     rst,
  jsfx_text_if.sink     text,
  jsfx_result_if.source result,
  jsfx_cfg_if.sink      cfg
);

  jsfx_pkg::cfg_t                 cfg_regs;
  jsfx_pkg::job_t                 job;
  jsfx_pkg::ram_wr_t              wr;
  logic                           hold;
  logic [jsfx_pkg::RAM_AW-1:0]    raddr;
  logic [7:0]                     rdata;

  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.key_chars   <= '0;
      cfg_regs.key_length  <= jsfx_pkg::KEY_LENGTH_W'(4);
      cfg_regs.value_limit <= jsfx_pkg::VALUE_LIMIT_W'(32);
    end else if (cfg.valid) begin
      case (cfg.index)
        jsfx_pkg::CFG_KEY_CHARS:
          cfg_regs.key_chars <= cfg.data[jsfx_pkg::KEY_CHARS_W-1:0];
        jsfx_pkg::CFG_KEY_LENGTH:
          cfg_regs.key_length <= cfg.data[jsfx_pkg::KEY_LENGTH_W-1:0];
        jsfx_pkg::CFG_VALUE_LIMIT:
          cfg_regs.value_limit <= cfg.data[jsfx_pkg::VALUE_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  jsfx_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .cfg  (cfg_regs),
    .hold (hold),
    .job  (job),
    .wr   (wr)
  );

  // Parser writes one bank while the drain reads the other
  jsfx_ram #(
    .WIDTH (8),
    .DEPTH (jsfx_pkg::RAM_DEPTH)
  ) u_value_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  jsfx_drain u_drain (
    .clk    (clk),
    .rst    (rst),
    .job    (job),
    .hold   (hold),
    .raddr  (raddr),
    .rdata  (rdata),
    .result (result)
  );

endmodule

`default_nettype wire
